// ----- sv/joystick_to_pointer_top_assert.svh -----
// assertion macros for the pointer block
`ifndef JOYSTICK_TO_POINTER_TOP_ASSERT_SVH
`define JOYSTICK_TO_POINTER_TOP_ASSERT_SVH

// checked only while out of reset
`define JTP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define JTP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/jtp_pkg.sv -----
`timescale 1ns / 1ps
package jtp_pkg;

  localparam int Channels   = 4;
  localparam int ChIdxW     = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int DeadZone   = 14;
  localparam int FullTilt   = 100;
  localparam int ClassicNum = 100;
  localparam int ClassicSh  = 7;
  localparam int SpanRaw    = FullTilt - DeadZone;
  localparam int Span       = (SpanRaw < 1) ? 1 : SpanRaw;
  localparam int SpanSq     = Span * Span;
  localparam int LutDepth   = Span + 1;
  localparam int LutIdxW    = $clog2(LutDepth);
  localparam int SpeedW     = 12;
  localparam int PosW       = 18;
  localparam int SumW       = PosW + 2;
  localparam int DimW       = 11;
  localparam int PixW       = 10;
  localparam int MaxDim     = 1024;
  localparam int CfgDataW   = 11;

  typedef enum logic [0:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_REMOTE  = 2'd0,
    MODE_IDLE    = 2'd1,
    MODE_POINTER = 2'd2
  } pointer_mode_e;

  typedef struct packed {
    logic [1:0]        channel;
    logic              remote_present;
    logic              remote_pointing;
    logic              remote_buttons_pressed;
    logic              classic_attached;
    logic              classic_buttons_pressed;
    logic              pad_buttons_pressed;
    logic signed [7:0] pad_stick_x;
    logic signed [7:0] pad_stick_y;
    logic signed [7:0] classic_stick_x;
    logic signed [7:0] classic_stick_y;
  } jtp_in_t;

  typedef struct packed {
    logic [1:0]     out_channel;
    pointer_mode_e  pointer_mode;
    logic [PixW-1:0] pointer_x;
    logic [PixW-1:0] pointer_y;
    logic           center_classic_stick;
  } jtp_out_t;

  typedef logic [SpeedW-1:0] speed_lut_t [LutDepth];

  // speed magnitude in q.8, rounded half up
  function automatic speed_lut_t build_speed_lut();
    speed_lut_t lut;
    for (int d = 0; d < LutDepth; d++) begin
      lut[d] = SpeedW'(256 + (13 * 256 * d * d + SpanSq / 2) / SpanSq);
    end
    return lut;
  endfunction

  localparam speed_lut_t SpeedLut = build_speed_lut();

  function automatic logic [7:0] abs8(logic signed [7:0] v);
    return v[7] ? 8'(-v) : 8'(v);
  endfunction

  // classic stick scaled by 100/128, truncated toward zero
  function automatic logic signed [7:0] scale_classic(logic signed [7:0] v);
    logic [14:0] prod;
    logic [7:0]  m;
    prod = 15'(abs8(v)) * 15'(ClassicNum);
    m    = 8'(prod >> ClassicSh);
    return v[7] ? $signed(8'(-m)) : $signed(m);
  endfunction

  function automatic logic [DimW-1:0] sat_dim(logic [DimW-1:0] v);
    if (v == '0) begin
      return DimW'(1);
    end else if (v > DimW'(MaxDim)) begin
      return DimW'(MaxDim);
    end
    return v;
  endfunction

  function automatic logic [PosW-1:0] clamp_pos(logic signed [SumW-1:0] p,
                                                logic [PosW-1:0] hi);
    if (p < 0) begin
      return '0;
    end else if (p > $signed({2'b00, hi})) begin
      return hi;
    end
    return p[PosW-1:0];
  endfunction

endpackage

// ----- sv/jtp_if.sv -----
`timescale 1ns / 1ps
interface jtp_in_if;
  import jtp_pkg::*;
  logic    valid;
  logic    ready;
  jtp_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface jtp_out_if;
  import jtp_pkg::*;
  logic     valid;
  logic     ready;
  jtp_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/jtp_speed.sv -----
`timescale 1ns / 1ps
module jtp_speed (
  input  logic signed [7:0]               stick_i,
  output logic signed [jtp_pkg::SpeedW:0] speed_o
);
  import jtp_pkg::*;

  logic [7:0]         mag;
  logic [7:0]         excess;
  logic [SpeedW-1:0]  lut_val;

  always_comb begin
    mag    = abs8(stick_i);
    excess = mag - 8'(DeadZone);
    if (excess > 8'(Span)) begin
      excess = 8'(Span);
    end
    lut_val = SpeedLut[excess[LutIdxW-1:0]];
    if (mag <= 8'(DeadZone)) begin
      speed_o = '0;
    end else if (stick_i[7]) begin
      speed_o = -$signed({1'b0, lut_val});
    end else begin
      speed_o = $signed({1'b0, lut_val});
    end
  end

endmodule

// ----- sv/joystick_to_pointer_top.sv -----
`timescale 1ns / 1ps
`include "joystick_to_pointer_top_assert.svh"
// Stick-driven pointer, one result per frame item. An item is taken into an input register,
// and when it advances, one read-modify-write of the per-channel state (position, placed
// and active flags) forms the result, which is held in an output register until transferred.
// Throughput is one item per clock while the output is accepted, also for consecutive items on
// the same channel; each result passes the input register and then the output register. The
// speed curve is a constant lookup table of 87 entries, so the curve itself needs no multiplier.
// The user must write screen size through the configuration port only while no item is in
// flight; the block itself does not enforce this.
module joystick_to_pointer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  jtp_in_if.sink                        in_i,
  jtp_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  jtp_pkg::cfg_reg_e             cfg_idx_i,
  input  logic [jtp_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import jtp_pkg::*;

  typedef struct packed {
    logic            act_we;
    logic            act_val;
    logic            pos_we;
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
  } state_wr_t;

  logic [DimW-1:0] width_q, height_q;

  logic            s1_valid_q;
  jtp_in_t         s1_q;
  logic            s1_adv;

  logic            res_valid_q, res_valid_d;
  jtp_out_t        res_q, res_d;

  logic            active_q [Channels];
  logic            placed_q [Channels];
  logic [PosW-1:0] pos_x_q  [Channels];
  logic [PosW-1:0] pos_y_q  [Channels];

  logic [ChIdxW-1:0]       idx;
  logic                    ch_ok;
  logic                    classic, takeover, use_classic, moved, act_now;
  logic signed [7:0]       sel_x, sel_y;
  logic signed [SpeedW:0]  spd_x, spd_y;
  logic [DimW-1:0]         w_sat, h_sat;
  logic [PosW-1:0]         hi_x, hi_y, base_x, base_y;
  logic signed [SumW-1:0]  sum_x, sum_y;
  state_wr_t               wr;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(640);
      height_q <= DimW'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_SCREEN_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_adv     = s1_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign out_o.valid = res_valid_q;
  assign out_o.data  = res_q;

  always_comb begin
    res_valid_d = res_valid_q;
    if (s1_adv) begin
      res_valid_d = 1'b1;
    end else if (out_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q <= in_i.data;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  // stick selection
  assign classic     = s1_q.remote_present & s1_q.classic_attached;
  assign takeover    = s1_q.remote_present & (s1_q.remote_pointing | s1_q.remote_buttons_pressed);
  assign use_classic = classic && (abs8(s1_q.pad_stick_x) <= 8'(DeadZone))
                               && (abs8(s1_q.pad_stick_y) <= 8'(DeadZone));
  assign sel_x = use_classic ? scale_classic(s1_q.classic_stick_x) : s1_q.pad_stick_x;
  assign sel_y = use_classic ? scale_classic(s1_q.classic_stick_y) : s1_q.pad_stick_y;

  jtp_speed u_speed_x (.stick_i(sel_x), .speed_o(spd_x));
  jtp_speed u_speed_y (.stick_i(sel_y), .speed_o(spd_y));

  // position update
  assign idx     = s1_q.channel[ChIdxW-1:0];
  assign ch_ok   = int'(s1_q.channel) < Channels;
  assign moved   = (spd_x != '0) || (spd_y != '0);
  assign act_now = active_q[idx] | moved | s1_q.pad_buttons_pressed
                 | (classic & s1_q.classic_buttons_pressed);

  assign w_sat  = sat_dim(width_q);
  assign h_sat  = sat_dim(height_q);
  assign hi_x   = {PixW'(w_sat - DimW'(1)), 8'h00};
  assign hi_y   = {PixW'(h_sat - DimW'(1)), 8'h00};
  assign base_x = placed_q[idx] ? pos_x_q[idx] : {w_sat[DimW-1:1], 8'h00};
  assign base_y = placed_q[idx] ? pos_y_q[idx] : {h_sat[DimW-1:1], 8'h00};
  assign sum_x  = $signed({2'b00, base_x}) + SumW'(spd_x);
  assign sum_y  = $signed({2'b00, base_y}) - SumW'(spd_y);

  always_comb begin
    wr                         = '0;
    wr.pos_x                   = clamp_pos(sum_x, hi_x);
    wr.pos_y                   = clamp_pos(sum_y, hi_y);
    res_d                      = '0;
    res_d.out_channel          = s1_q.channel;
    res_d.pointer_mode         = MODE_IDLE;
    if (ch_ok) begin
      wr.act_we = 1'b1;
      if (takeover) begin
        wr.act_val         = 1'b0;
        res_d.pointer_mode = MODE_REMOTE;
      end else begin
        wr.act_val = act_now;
        if (act_now) begin
          wr.pos_we                  = 1'b1;
          res_d.pointer_mode         = MODE_POINTER;
          res_d.pointer_x            = wr.pos_x[PosW-1:8];
          res_d.pointer_y            = wr.pos_y[PosW-1:8];
          res_d.center_classic_stick = classic;
        end
      end
    end
  end

  // per-channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Channels; i++) begin
        active_q[i] <= 1'b0;
        placed_q[i] <= 1'b0;
      end
    end else if (s1_adv) begin
      if (wr.act_we) begin
        active_q[idx] <= wr.act_val;
      end
      if (wr.pos_we) begin
        placed_q[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && wr.pos_we) begin
      pos_x_q[idx] <= wr.pos_x;
      pos_y_q[idx] <= wr.pos_y;
    end
  end

  `JTP_ASSERT(a_pointer_sets_state, s1_adv && (res_d.pointer_mode == MODE_POINTER) |=> active_q[$past(idx)] && placed_q[$past(idx)], "pointer result without active placed channel")
  `JTP_ASSERT(a_remote_clears_active, s1_adv && (res_d.pointer_mode == MODE_REMOTE) |=> !active_q[$past(idx)], "remote takeover left channel active")
  `JTP_ASSERT(a_centre_only_pointer, res_valid_q && res_q.center_classic_stick |-> res_q.pointer_mode == MODE_POINTER, "classic centring outside pointer mode")
  `JTP_ASSERT_ALWAYS(a_ready_when_empty, !s1_valid_q |-> in_i.ready, "input stalled with empty input register")

endmodule
